@@ hdl/u2rd_pkg.sv @@
`default_nettype none
package u2rd_pkg;

  localparam int MAX_RADIX   = 32;
  localparam int MAX_DIGITS  = 64;
  localparam int ALPHA_SLOTS = 32;
  localparam int MIN_RADIX   = 2;

  localparam int VALUE_W = 64;
  localparam int LEN_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = $clog2(MAX_RADIX);
  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int COUNT_W = ADDR_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIV_BITS = 8;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD3 = 3'd4;

  typedef struct packed {
    logic [LEN_W-1:0]                         len;
    logic [ALPHA_SLOTS-1:0][CHAR_W-1:0]       alpha;
  } cfg_t;

  typedef struct packed {
    logic               bad;
    logic [VALUE_W-1:0] value;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
    job_t head;
  } q_stat_t;

endpackage
`default_nettype wire

@@ hdl/u2rd_ram.sv @@
`default_nettype none
module u2rd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/u2rd_front.sv @@
`default_nettype none
module u2rd_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire u2rd_pkg::cfg_t          cfg,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [63:0]             in_value,
  input  wire u2rd_pkg::q_stat_t       q_stat,
  output u2rd_pkg::q_push_t            q_push
);
  import u2rd_pkg::*;

  logic               vld_r;
  logic [VALUE_W-1:0] val_r;
  logic               bad_r;
  logic               bad_nxt;
  logic               accept;
  logic               push;

  // The alphabet check is registered. The user must change configuration only while idle;
  // the block does not enforce it. Then the flag has settled before a held word is pushed.
  always_comb begin
    bad_nxt = (cfg.len < LEN_W'(MIN_RADIX)) || (cfg.len > LEN_W'(MAX_RADIX));
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      if (LEN_W'(i) < cfg.len) begin
        if (cfg.alpha[i] == CHAR_MINUS || cfg.alpha[i] == CHAR_PLUS) begin
          bad_nxt = 1'b1;
        end
        for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
          if (LEN_W'(j) < cfg.len && cfg.alpha[j] == cfg.alpha[i]) begin
            bad_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign push     = vld_r && !q_stat.full;
  assign in_stall = vld_r && q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      bad_r <= 1'b1;
    end else begin
      bad_r <= bad_nxt;
      if (accept) begin
        vld_r <= 1'b1;
      end else if (push) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r <= in_value;
    end
  end

  assign q_push.push      = push;
  assign q_push.job.bad   = bad_r;
  assign q_push.job.value = val_r;

endmodule
`default_nettype wire

@@ hdl/u2rd_fifo.sv @@
`default_nettype none
module u2rd_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire u2rd_pkg::q_push_t   q_push,
  input  wire logic                pop,
  output u2rd_pkg::q_stat_t        q_stat
);
  import u2rd_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_stat.head  = mem_r[rd_ptr_r];

  assign do_push = q_push.push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.job;
    end
  end

endmodule
`default_nettype wire

@@ hdl/u2rd_back.sv @@
`default_nettype none
module u2rd_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire u2rd_pkg::cfg_t        cfg,
  input  wire u2rd_pkg::q_stat_t     q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_digit_char,
  output logic                       out_last,
  output logic                       out_bad_alphabet,
  output logic [6:0]                 out_digit_count
);
  import u2rd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]           state_r;
  logic [VALUE_W-1:0]   dvd_r;
  logic [DIGIT_W-1:0]   rem_r;
  logic [STEP_W-1:0]    step_r;
  logic [COUNT_W-1:0]   cnt_r;
  logic [ADDR_W-1:0]    rd_idx_r;

  logic [VALUE_W-1:0]   dvd_nxt;
  logic [DIGIT_W-1:0]   rem_nxt;
  logic                 digit_done;
  logic                 out_free;
  logic                 emit;
  logic                 ram_wr;
  logic                 ram_rd;
  logic [DIGIT_W-1:0]   ram_q;

  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;
  logic                 out_bad_r;
  logic [COUNT_W-1:0]   out_count_r;

  // Eight restoring division steps a cycle: the top byte of the dividend is
  // shifted into the remainder and the quotient bits refill the low byte.
  always_comb begin
    logic [DIGIT_W:0]     part;
    logic [DIGIT_W-1:0]   rem;
    logic [DIV_BITS-1:0]  qbits;
    rem   = rem_r;
    qbits = '0;
    part  = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      part = {rem, dvd_r[VALUE_W-1-b]};
      if (part >= cfg.len) begin
        part = part - cfg.len;
        qbits[DIV_BITS-1-b] = 1'b1;
      end
      rem = part[DIGIT_W-1:0];
    end
    rem_nxt = rem;
    dvd_nxt = {dvd_r[VALUE_W-DIV_BITS-1:0], qbits};
  end

  assign digit_done = (state_r == S_DIV) && (step_r == STEP_W'(DIV_STEPS - 1));
  assign out_free   = !out_valid_r || !out_stall;
  assign pop        = (state_r == S_IDLE) && !q_stat.empty && (!q_stat.head.bad || out_free);
  assign emit       = (state_r == S_EMIT) && out_free;
  assign ram_wr     = digit_done;
  assign ram_rd     = (state_r == S_RD);

  u2rd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (rem_nxt),
    .rd_en   (ram_rd),
    .rd_addr (rd_idx_r),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pop && !q_stat.head.bad) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (digit_done && (dvd_nxt == '0 || cnt_r == COUNT_W'(MAX_DIGITS - 1))) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            state_r <= (rd_idx_r == '0) ? S_IDLE : S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        dvd_r  <= q_stat.head.value;
        rem_r  <= '0;
        step_r <= '0;
        cnt_r  <= '0;
      end
      S_DIV: begin
        step_r <= step_r + STEP_W'(1);
        if (digit_done) begin
          // The quotient is complete; start the next digit from a clean remainder.
          dvd_r    <= dvd_nxt;
          rem_r    <= '0;
          cnt_r    <= cnt_r + COUNT_W'(1);
          rd_idx_r <= cnt_r[ADDR_W-1:0];
        end else begin
          dvd_r <= dvd_nxt;
          rem_r <= rem_nxt;
        end
      end
      S_EMIT: begin
        if (emit) begin
          rd_idx_r <= rd_idx_r - ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit || (pop && q_stat.head.bad)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_stat.head.bad) begin
      out_char_r  <= '0;
      out_last_r  <= 1'b1;
      out_bad_r   <= 1'b1;
      out_count_r <= '0;
    end else if (emit) begin
      out_char_r  <= cfg.alpha[ram_q];
      out_last_r  <= (rd_idx_r == '0);
      out_bad_r   <= 1'b0;
      out_count_r <= (rd_idx_r == '0) ? cnt_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_char   = out_char_r;
  assign out_last         = out_last_r;
  assign out_bad_alphabet = out_bad_r;
  assign out_digit_count  = out_count_r;

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_last_r && out_count_r == '0 && out_char_r == '0)
    else $error("error word is not a lone final word");

  a_count_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bad_r |-> (out_last_r == (out_count_r != '0)))
    else $error("digit count and final flag disagree");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !pop)
    else $error("job taken while a conversion is running");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < COUNT_W'(MAX_DIGITS))
    else $error("digit buffer overrun");

endmodule
`default_nettype wire

@@ hdl/unsigned_to_radix_digits.sv @@
// Flow: the front register, then the job queue, then division digit by digit, and per
// emitted digit a registered digit buffer read, then the output word.
// Worst case is radix 2 with a full 64-bit value, which gives the most digits.
// An invalid alphabet gives its single error word after the front register and queue.
// The next input is held in a two-entry job queue while a conversion runs.
// Synchronous reset (rst_n low) clears configuration and control state and the queue.
`default_nettype none
module unsigned_to_radix_digits (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_digit_char,
  output logic             out_last,
  output logic             out_bad_alphabet,
  output logic [6:0]       out_digit_count
);
  import u2rd_pkg::*;

  cfg_t    cfg_r;
  q_push_t q_push;
  q_stat_t q_stat;
  logic    pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LEN:   cfg_r.len          <= cfg_wr_data[LEN_W-1:0];
        REG_WORD0: cfg_r.alpha[7:0]   <= cfg_wr_data;
        REG_WORD1: cfg_r.alpha[15:8]  <= cfg_wr_data;
        REG_WORD2: cfg_r.alpha[23:16] <= cfg_wr_data;
        REG_WORD3: cfg_r.alpha[31:24] <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  u2rd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  u2rd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat)
  );

  u2rd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit_char   (out_digit_char),
    .out_last         (out_last),
    .out_bad_alphabet (out_bad_alphabet),
    .out_digit_count  (out_digit_count)
  );

endmodule
`default_nettype wire
